### rtl/tle_pkg.sv
`default_nettype none

package tle_pkg;

    // Width of the cursor and length result fields.
    localparam int unsigned CNT_W = 6;

    localparam logic [7:0] CH_CTRL_DEL   = 8'd1;
    localparam logic [7:0] CH_CTRL_LEFT  = 8'd2;
    localparam logic [7:0] CH_CTRL_RIGHT = 8'd3;
    localparam logic [7:0] CH_BS         = 8'd8;
    localparam logic [7:0] CH_NL         = 8'd10;
    localparam logic [7:0] CH_ESC        = 8'd27;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_THREE      = 8'd51;
    localparam logic [7:0] CH_UP_C       = 8'd67;
    localparam logic [7:0] CH_UP_D       = 8'd68;
    localparam logic [7:0] CH_LBRACK     = 8'd91;
    localparam logic [7:0] CH_TILDE      = 8'd126;
    localparam logic [7:0] CH_DEL        = 8'd127;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_CSI,
        ESC_CSI3
    } t_esc;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BACK,
        CMD_DELETE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_INSERT,
        CMD_ENTER
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_RESULT,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        t_esc esc;
    } t_decode;

    // Map a byte outside any escape sequence to its editing command; Enter and Escape are handled in decode.
    function automatic t_cmd plain_cmd(input logic [7:0] c);
        t_cmd cmd;
        unique case (c) inside
            CH_BS, CH_DEL: cmd = CMD_BACK;
            CH_CTRL_DEL:   cmd = CMD_DELETE;
            CH_CTRL_LEFT:  cmd = CMD_LEFT;
            CH_CTRL_RIGHT: cmd = CMD_RIGHT;
            default:       cmd = (c >= CH_SPACE) ? CMD_INSERT : CMD_NONE;
        endcase
        return cmd;
    endfunction

    // Advance the escape parser by one byte; a byte that breaks a sequence
    // falls back to its plain_cmd meaning, which gives Enter and Escape no command.
    function automatic t_decode decode(input t_esc esc, input logic [7:0] c);
        t_decode d;
        d.esc = ESC_IDLE;
        d.cmd = plain_cmd(c);
        unique case (esc)
            ESC_IDLE: begin
                if (c == CH_ESC) begin
                    d.esc = ESC_SEEN;
                    d.cmd = CMD_NONE;
                end else if (c == CH_NL) begin
                    d.cmd = CMD_ENTER;
                end
            end
            ESC_SEEN: begin
                if (c == CH_LBRACK) begin
                    d.esc = ESC_CSI;
                    d.cmd = CMD_NONE;
                end
            end
            ESC_CSI: begin
                if (c == CH_UP_C) begin
                    d.cmd = CMD_RIGHT;
                end else if (c == CH_UP_D) begin
                    d.cmd = CMD_LEFT;
                end else if (c == CH_THREE) begin
                    d.esc = ESC_CSI3;
                    d.cmd = CMD_NONE;
                end
            end
            ESC_CSI3: begin
                if (c == CH_TILDE) begin
                    d.cmd = CMD_DELETE;
                end
            end
            default: begin
                d.esc = ESC_IDLE;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/tle_ram.sv
`default_nettype none

module tle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/terminal_line_editor_core.sv
// Terminal line editor: takes received terminal bytes and edits one line.
// Input channel: i_rx_valid / o_rx_stall carry one word (i_rx_byte) per
// handshake. Output channel: o_res_valid / i_res_stall carry one result word
// (o_out_char, o_char_valid, o_cursor_pos, o_line_length, o_line_end).
// Every byte other than Enter yields one result with the cursor and length
// after the edit. Enter yields one result per line byte, in order, the last
// flagged by o_line_end; on an empty line it yields a single empty result
// with o_line_end set.
// Timing: one word at a time. A byte that moves no stored data passes
// through ST_RESULT into the result register; the next word is taken once
// the state is back in ST_IDLE. An insert or a delete moves its stored
// bytes through the line RAM one per cycle in ST_SHIFT, then goes through
// ST_RESULT. Enter reads the line RAM once per byte, through ST_EMIT_RD and
// then ST_EMIT for each result; the single RAM port pair sets this pace.
// A finished result sits in an output register; while the receiver stalls,
// the next result waits and o_rx_stall stays high until the last result of
// the current word has entered that register.
// Reset clears cursor, length, escape parser and output valid; the line RAM
// holds no reset value and is only read below the current length.
`default_nettype none

module terminal_line_editor_core #(
    parameter int unsigned LINE_LEN = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic [5:0]      o_cursor_pos,
    output logic [5:0]      o_line_length,
    output logic            o_line_end
);

    localparam int unsigned AW = $clog2(LINE_LEN);
    localparam logic [AW-1:0] MAX_LEN = AW'(LINE_LEN - 1);
    localparam logic [AW-1:0] ONE = AW'(1);

    // control state
    tle_pkg::t_state r_state, n_state;
    tle_pkg::t_esc   r_esc, n_esc;
    logic [AW-1:0]   r_cursor, n_cursor;
    logic [AW-1:0]   r_length, n_length;
    logic            r_pend, n_pend;
    logic            r_ovalid, n_ovalid;

    // work registers
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_place, n_place;
    logic [7:0]      r_byte, n_byte;
    logic            r_ins, n_ins;
    logic            r_end, n_end;

    // result register payload
    logic [7:0]      r_ochar, n_ochar;
    logic            r_ocvalid, n_ocvalid;
    logic [AW-1:0]   r_ocursor, n_ocursor;
    logic [AW-1:0]   r_olength, n_olength;
    logic            r_oend, n_oend;

    // line RAM port
    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [7:0]      w_wdata, w_rdata;

    tle_pkg::t_decode w_dec;
    logic             w_accept;
    logic             w_slot_free;
    logic             w_shift;
    logic             w_issue;
    logic             w_shift_done;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_dec       = tle_pkg::decode(r_esc, i_rx_byte);
    assign w_accept    = (r_state == tle_pkg::ST_IDLE) && i_rx_valid;
    assign w_slot_free = !r_ovalid || !i_res_stall;
    assign w_issue     = (r_cnt != '0);
    assign w_shift_done = !w_issue && !r_pend;

    // edits that move stored bytes
    assign w_shift = ((w_dec.cmd == tle_pkg::CMD_BACK)   && (r_cursor != '0))
                  || ((w_dec.cmd == tle_pkg::CMD_DELETE) && (r_cursor < r_length))
                  || ((w_dec.cmd == tle_pkg::CMD_INSERT) && (r_length < MAX_LEN));

    assign o_rx_stall    = (r_state != tle_pkg::ST_IDLE);
    assign o_res_valid   = r_ovalid;
    assign o_out_char    = r_ochar;
    assign o_char_valid  = r_ocvalid;
    assign o_cursor_pos  = tle_pkg::CNT_W'(r_ocursor);
    assign o_line_length = tle_pkg::CNT_W'(r_olength);
    assign o_line_end    = r_oend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tle_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if ((w_dec.cmd == tle_pkg::CMD_ENTER) && (r_length != '0)) begin
                        n_state = tle_pkg::ST_EMIT_RD;
                    end else if (w_shift) begin
                        n_state = tle_pkg::ST_SHIFT;
                    end else begin
                        n_state = tle_pkg::ST_RESULT;
                    end
                end
            end
            tle_pkg::ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = tle_pkg::ST_RESULT;
                end
            end
            tle_pkg::ST_RESULT: begin
                if (w_slot_free) begin
                    n_state = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_EMIT_RD: begin
                n_state = tle_pkg::ST_EMIT;
            end
            tle_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = (r_cnt == ONE) ? tle_pkg::ST_IDLE : tle_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = tle_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_esc     = r_esc;
        n_cursor  = r_cursor;
        n_length  = r_length;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_rptr    = r_rptr;
        n_wptr    = r_wptr;
        n_place   = r_place;
        n_byte    = r_byte;
        n_ins     = r_ins;
        n_end     = r_end;
        n_ovalid  = r_ovalid && i_res_stall;
        n_ochar   = r_ochar;
        n_ocvalid = r_ocvalid;
        n_ocursor = r_ocursor;
        n_olength = r_olength;
        n_oend    = r_oend;
        w_we      = 1'b0;
        w_waddr   = r_wptr;
        w_wdata   = w_rdata;
        w_re      = 1'b0;
        w_raddr   = r_rptr;

        unique case (r_state)
            tle_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_esc  = w_dec.esc;
                    n_end  = 1'b0;
                    n_pend = 1'b0;
                    unique case (w_dec.cmd)
                        tle_pkg::CMD_BACK: begin
                            // remove the byte left of the cursor
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - ONE;
                                n_length = r_length - ONE;
                                n_cnt    = r_length - r_cursor;
                                n_rptr   = r_cursor;
                                n_ins    = 1'b0;
                            end
                        end
                        tle_pkg::CMD_DELETE: begin
                            if (r_cursor < r_length) begin
                                n_length = r_length - ONE;
                                n_cnt    = r_length - r_cursor - ONE;
                                n_rptr   = r_cursor + ONE;
                                n_ins    = 1'b0;
                            end
                        end
                        tle_pkg::CMD_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - ONE;
                            end
                        end
                        tle_pkg::CMD_RIGHT: begin
                            if (r_cursor < r_length) begin
                                n_cursor = r_cursor + ONE;
                            end
                        end
                        tle_pkg::CMD_INSERT: begin
                            // open a gap at the cursor, then drop the byte in
                            if (r_length < MAX_LEN) begin
                                n_cursor = r_cursor + ONE;
                                n_length = r_length + ONE;
                                n_cnt    = r_length - r_cursor;
                                n_rptr   = r_length - ONE;
                                n_place  = r_cursor;
                                n_byte   = i_rx_byte;
                                n_ins    = 1'b1;
                            end
                        end
                        tle_pkg::CMD_ENTER: begin
                            n_cursor = '0;
                            n_length = '0;
                            n_cnt    = r_length;
                            n_rptr   = '0;
                            n_end    = 1'b1;
                        end
                        default: begin
                            n_end = 1'b0;
                        end
                    endcase
                end
            end
            tle_pkg::ST_SHIFT: begin
                // stream one byte per cycle: read ahead, write one behind
                w_re    = w_issue;
                w_raddr = r_rptr;
                n_pend  = w_issue;
                if (w_issue) begin
                    n_cnt  = r_cnt - ONE;
                    n_rptr = r_ins ? (r_rptr - ONE) : (r_rptr + ONE);
                    n_wptr = r_ins ? (r_rptr + ONE) : (r_rptr - ONE);
                end
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_wptr;
                    w_wdata = w_rdata;
                end else if (!w_issue && r_ins) begin
                    w_we    = 1'b1;
                    w_waddr = r_place;
                    w_wdata = r_byte;
                end
            end
            tle_pkg::ST_RESULT: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ochar   = '0;
                    n_ocvalid = 1'b0;
                    n_ocursor = r_cursor;
                    n_olength = r_length;
                    n_oend    = r_end;
                end
            end
            tle_pkg::ST_EMIT_RD: begin
                w_re    = 1'b1;
                w_raddr = r_rptr;
            end
            tle_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ochar   = w_rdata;
                    n_ocvalid = 1'b1;
                    n_ocursor = r_cursor;
                    n_olength = r_length;
                    n_oend    = (r_cnt == ONE);
                    n_cnt     = r_cnt - ONE;
                    n_rptr    = r_rptr + ONE;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tle_pkg::ST_IDLE;
            r_esc    <= tle_pkg::ESC_IDLE;
            r_cursor <= '0;
            r_length <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_esc    <= n_esc;
            r_cursor <= n_cursor;
            r_length <= n_length;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_rptr    <= n_rptr;
        r_wptr    <= n_wptr;
        r_place   <= n_place;
        r_byte    <= n_byte;
        r_ins     <= n_ins;
        r_end     <= n_end;
        r_ochar   <= n_ochar;
        r_ocvalid <= n_ocvalid;
        r_ocursor <= n_ocursor;
        r_olength <= n_olength;
        r_oend    <= n_oend;
    end

endmodule

`default_nettype wire
